// ===== src/fpnas_pkg.sv =====
// Package for the fixed-pattern-noise average/subtract block.
// Holds field widths, item kinds, reference channel numbers, stage structs and helpers.
// No dependencies.
package fpnas_pkg;

  localparam int SAMPLES = 512;
  localparam int ADDR_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  localparam int KIND_W = 2;
  localparam int CH_W = 7;
  localparam int IDX_W = 9;
  localparam int SMP_W = 12;
  localparam int SUM_W = 14;
  localparam int FRAC_W = 4;
  localparam int NUM_W = SUM_W + FRAC_W;
  localparam int OUT_W = 17;
  localparam int CNT_W = 3;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CORRECT = 2'd2;

  localparam logic [CH_W-1:0] REF_CH0 = 7'd11;
  localparam logic [CH_W-1:0] REF_CH1 = 7'd22;
  localparam logic [CH_W-1:0] REF_CH2 = 7'd45;
  localparam logic [CH_W-1:0] REF_CH3 = 7'd56;

  // floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT for n < 2**19
  localparam int DIV3_SHIFT = 19;
  localparam logic [NUM_W:0] DIV3_MUL = 19'd174763;
  localparam int PROD_W = 2 * (NUM_W + 1);

  localparam logic signed [OUT_W+2:0] OUT_MIN = -20'sd65536;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int FIFO_CW = 3;

  typedef struct packed {
    logic [OUT_W-1:0] corrected;
    logic             is_reference;
    logic             no_reference;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [SMP_W-1:0] sample;
    logic             is_ref;
    logic [CNT_W-1:0] count;
    logic [NUM_W-1:0] num;
  } avg_in_t;

  function automatic logic [3:0] ref_bit(input logic [CH_W-1:0] ch);
    logic [3:0] b;
    b = 4'b0000;
    if (ch == REF_CH0) b = 4'b0001;
    if (ch == REF_CH1) b = 4'b0010;
    if (ch == REF_CH2) b = 4'b0100;
    if (ch == REF_CH3) b = 4'b1000;
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] count_present(input logic [3:0] m);
    return CNT_W'(m[0]) + CNT_W'(m[1]) + CNT_W'(m[2]) + CNT_W'(m[3]);
  endfunction

endpackage

// ===== src/fpnas_sum_mem.sv =====
// Reference sum memory: one write port, one read port, registered read data.
// Generic over depth and width; no package dependency.
module fpnas_sum_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 14,
  parameter int AW = 9
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/fpnas_avg.sv =====
// Average and subtract stage: divides the rounded numerator by the reference count,
// subtracts it from a non-reference scaled sample, saturates. Depends on fpnas_pkg.
module fpnas_avg import fpnas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  avg_in_t stage_in,
  output logic    res_valid,
  output result_t res
);

  avg_in_t s2;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0] avg;
  logic signed [OUT_W+2:0] scaled;
  logic signed [OUT_W+2:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= stage_in.valid;
    end
    s2.sample <= stage_in.sample;
    s2.is_ref <= stage_in.is_ref;
    s2.count <= stage_in.count;
    s2.num <= stage_in.num;
  end

  always_comb begin
    prod = PROD_W'(s2.num) * PROD_W'(DIV3_MUL);
    case (s2.count)
      3'd1: avg = s2.num;
      3'd2: avg = s2.num >> 1;
      3'd3: avg = NUM_W'(prod >> DIV3_SHIFT);
      3'd4: avg = s2.num >> 2;
      default: avg = '0;
    endcase
    scaled = $signed({3'b000, s2.sample, {FRAC_W{1'b0}}});
    diff = scaled - $signed({2'b00, avg});
    if (s2.is_ref || s2.count == '0) begin
      diff = scaled;
    end
    if (diff < OUT_MIN) begin
      diff = OUT_MIN;
    end
  end

  assign res_valid = s2.valid;
  assign res.corrected = OUT_W'(diff);
  assign res.is_reference = s2.is_ref;
  assign res.no_reference = (s2.count == '0);

endmodule

// ===== src/fpnas_out_buf.sv =====
// Output buffer: small register queue of result items toward the stalling receiver.
// Depends on fpnas_pkg.
module fpnas_out_buf import fpnas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  result_t              wr_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data,
  output logic [FIFO_CW-1:0]   count
);

  result_t buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic rd;

  assign out_valid = (count != '0);
  assign rd = out_valid && !out_stall;
  assign out_data = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      buf_q[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (rd) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + FIFO_CW'(wr) - FIFO_CW'(rd);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FIFO_CW'(FIFO_DEPTH))
    else $error("output buffer overfilled");
  assert property (@(posedge clk) disable iff (rst)
    wr && !rd |-> count < FIFO_CW'(FIFO_DEPTH))
    else $error("write into full output buffer");

endmodule

// ===== src/fpn_average_subtract.sv =====
// Top level of the fixed-pattern-noise average/subtract block.
// Depends on fpnas_pkg, fpnas_sum_mem, fpnas_avg and fpnas_out_buf.
//
// Input channel (in_valid/in_stall) carries kind, channel, sample_index, sample.
// A clear item zeroes the per-sample reference sums and the presence mask; an
// accumulate item adds a reference channel sample to its sum; a correct item
// returns one result (corrected, is_reference, no_reference) on the output
// channel (out_valid/out_stall).
// Throughput: one item per cycle while in_stall is low, set by the sum memory
// read-modify-write, which forwards a write to a read of the same entry in the
// next cycle. An accepted item passes the stage-1 registers, the fpnas_avg stage
// register and the output buffer before its result is offered on out_valid.
// A clear item, and reset, start a sweep that writes zero to all SAMPLES (512)
// sum entries, one per cycle; in_stall is high during the sweep.
// A stalled receiver holds results in a 4-entry buffer; in_stall rises once the
// buffer plus results in flight would fill it, so items of every kind wait
// until the receiver drains.
module fpn_average_subtract import fpnas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_W-1:0]       kind,
  input  logic [CH_W-1:0]         channel,
  input  logic [IDX_W-1:0]        sample_index,
  input  logic [SMP_W-1:0]        sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] corrected,
  output logic                    is_reference,
  output logic                    no_reference
);

  logic accept;
  logic clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic [3:0] present;

  logic s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [ADDR_W-1:0] s1_addr;
  logic s1_in_range;
  logic [3:0] s1_bit;
  logic [SMP_W-1:0] s1_sample;

  logic fwd_hit;
  logic [SUM_W-1:0] fwd_data;
  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] sum_cur;
  logic [SUM_W-1:0] acc_data;
  logic acc_wr;
  logic [CNT_W-1:0] count;

  logic mem_wr;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [SUM_W-1:0] mem_wr_data;

  avg_in_t avg_in;
  logic res_valid;
  result_t res;
  result_t out_data;
  logic [FIFO_CW-1:0] buf_count;
  logic [FIFO_CW-1:0] in_flight;

  function automatic logic [SUM_W-1:0] sample_to_sum(input logic [SMP_W-1:0] s);
    return SUM_W'(s);
  endfunction

  assign in_flight = buf_count + FIFO_CW'(s1_valid && s1_kind == KIND_CORRECT)
                     + FIFO_CW'(res_valid);
  assign in_stall = clearing || (in_flight >= FIFO_CW'(FIFO_DEPTH));
  assign accept = in_valid && !in_stall;

  // stage 1: read data arrives; modify and write back
  assign sum_cur = fwd_hit ? fwd_data : rd_data;
  assign acc_data = sum_cur + SUM_W'(sample_to_sum(s1_sample));
  assign acc_wr = s1_valid && s1_kind == KIND_ACC && s1_bit != 4'b0000 && s1_in_range;
  assign count = count_present(present);

  assign mem_wr = clearing || acc_wr;
  assign mem_wr_addr = clearing ? clr_addr : s1_addr;
  assign mem_wr_data = clearing ? '0 : acc_data;

  fpnas_sum_mem #(
    .DEPTH (SAMPLES),
    .WIDTH (SUM_W),
    .AW    (ADDR_W)
  ) u_sum_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(sample_index)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
      present <= '0;
      fwd_hit <= 1'b0;
    end else begin
      s1_valid <= accept && (kind == KIND_ACC || kind == KIND_CORRECT);
      fwd_hit <= accept && acc_wr && (ADDR_W'(sample_index) == s1_addr);
      if (acc_wr) present <= present | s1_bit;
      if (accept && kind == KIND_CLEAR) begin
        clearing <= 1'b1;
        clr_addr <= '0;
        present <= '0;
      end else if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(SAMPLES - 1)) clearing <= 1'b0;
      end
    end
    fwd_data <= acc_data;
    s1_kind <= kind;
    s1_addr <= ADDR_W'(sample_index);
    s1_in_range <= (32'(sample_index) < 32'(SAMPLES));
    s1_bit <= ref_bit(channel);
    s1_sample <= sample;
  end

  always_comb begin
    avg_in.valid = s1_valid && s1_kind == KIND_CORRECT;
    avg_in.sample = s1_sample;
    avg_in.is_ref = (s1_bit != 4'b0000);
    avg_in.count = count;
    avg_in.num = (s1_in_range ? {sum_cur, {FRAC_W{1'b0}}} : '0) + NUM_W'(count >> 1);
  end

  fpnas_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .stage_in  (avg_in),
    .res_valid (res_valid),
    .res       (res)
  );

  fpnas_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .wr        (res_valid),
    .wr_data   (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (buf_count)
  );

  assign corrected = out_data.corrected;
  assign is_reference = out_data.is_reference;
  assign no_reference = out_data.no_reference;

  assert property (@(posedge clk) disable iff (rst) in_flight <= FIFO_CW'(FIFO_DEPTH))
    else $error("results in flight exceed output buffer space");
  assert property (@(posedge clk) disable iff (rst) clearing |-> present == 4'b0000)
    else $error("presence mask set during clear sweep");
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s1_valid)
    else $error("sum write collides with clear sweep");
  assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_CLEAR |=> clearing && clr_addr == '0)
    else $error("clear item did not start sweep");

endmodule

// ===== verif/fpn_average_subtract_tb.sv =====
// Self-checking testbench for fpn_average_subtract: frames of clear, reference
// accumulate and correct items, each result checked against an in-bench predictor.
// Depends on fpnas_pkg and the fpn_average_subtract RTL.
module fpn_average_subtract_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpnas_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1350;
  localparam int MAX_PRINTS = 100;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [KIND_W-1:0]       kind = KIND_CLEAR;
  logic [CH_W-1:0]         channel = '0;
  logic [IDX_W-1:0]        sample_index = '0;
  logic [SMP_W-1:0]        sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] corrected;
  logic                    is_reference;
  logic                    no_reference;

  logic [SUM_W-1:0] ref_sums [SAMPLES];
  logic [3:0]       ref_mask;
  result_t          expected_results [$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  hold_left = 0;

  fpn_average_subtract dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .channel(channel),
    .sample_index(sample_index),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .corrected(corrected),
    .is_reference(is_reference),
    .no_reference(no_reference)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("fpn_average_subtract_tb failed");
    $finish;
  end

  function automatic logic [3:0] presence_bit(input logic [CH_W-1:0] ch);
    case (ch)
      REF_CH0: return 4'b0001;
      REF_CH1: return 4'b0010;
      REF_CH2: return 4'b0100;
      REF_CH3: return 4'b1000;
      default: return 4'b0000;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] ref_channel(input int n);
    case (n)
      0: return REF_CH0;
      1: return REF_CH1;
      2: return REF_CH2;
      default: return REF_CH3;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    return CH_W'($urandom_range(0, 67));
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return IDX_W'($urandom_range(0, SAMPLES - 1));
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SMP_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Apply one accepted item to the frame state; queue the result it produces.
  task automatic track_item(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch,
                            input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] smp);
    logic [3:0] flag;
    int         count;
    int         value;
    int         avg;
    int         sum;
    result_t    r;
    flag = presence_bit(ch);
    case (k)
      KIND_CLEAR: begin
        foreach (ref_sums[i]) ref_sums[i] = '0;
        ref_mask = '0;
      end
      KIND_ACC: begin
        if (flag != 0 && idx < SAMPLES) begin
          ref_sums[idx] = ref_sums[idx] + smp;
          ref_mask = ref_mask | flag;
        end
      end
      KIND_CORRECT: begin
        count = $countones(ref_mask);
        value = 16 * int'(smp);
        if (flag == 0 && count != 0) begin
          sum = (idx < SAMPLES) ? int'(ref_sums[idx]) : 0;
          avg = (sum * 16 + count / 2) / count;
          value = value - avg;
          if (value > 65535) value = 65535;
          if (value < -65536) value = -65536;
        end
        r.corrected = OUT_W'(value);
        r.is_reference = (flag != 0);
        r.no_reference = (count == 0);
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch,
                           input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] smp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    channel <= ch;
    sample_index <= idx;
    sample <= smp;
    do @(posedge clk); while (in_stall);
    track_item(k, ch, idx, smp);
    if (!(k == KIND_UNUSED || (k == KIND_ACC && presence_bit(ch) == 0))) items_sent++;
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : receive
    result_t want;
    int      rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected, corrected %0d", corrected));
        end else begin
          want = expected_results.pop_front();
          if (corrected !== want.corrected)
            report_mismatch($sformatf("corrected %0d, expected %0d",
                                      corrected, $signed(want.corrected)));
          if (is_reference !== want.is_reference)
            report_mismatch($sformatf("is_reference %b, expected %b",
                                      is_reference, want.is_reference));
          if (no_reference !== want.no_reference)
            report_mismatch($sformatf("no_reference %b, expected %b",
                                      no_reference, want.no_reference));
        end
        rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_no_reference();
    send_item(KIND_CORRECT, 7'd0, 9'd0, 12'd4095);
    send_item(KIND_CORRECT, REF_CH3, 9'd511, 12'd0);
    send_item(KIND_CORRECT, 7'd67, 9'd256, 12'd2048);
    wait_results();
  endtask

  task automatic test_ignored_items();
    send_item(KIND_UNUSED, REF_CH0, 9'd3, 12'd4095);
    send_item(KIND_ACC, 7'd67, 9'd511, 12'd4095);
    send_item(KIND_ACC, 7'd0, 9'd0, 12'd4095);
    send_item(KIND_CORRECT, 7'd1, 9'd511, 12'd100);
    wait_results();
  endtask

  task automatic test_full_sum_and_wrap();
    for (int r = 0; r < 4; r++) send_item(KIND_ACC, ref_channel(r), 9'd511, 12'd4095);
    send_item(KIND_CORRECT, 7'd64, 9'd511, 12'd0);
    send_item(KIND_CORRECT, REF_CH1, 9'd511, 12'd1234);
    send_item(KIND_ACC, REF_CH0, 9'd511, 12'd4095);
    send_item(KIND_CORRECT, 7'd42, 9'd511, 12'd4095);
    send_item(KIND_CORRECT, 7'd63, 9'd0, 12'd4095);
    wait_results();
  endtask

  task automatic test_saturation_and_rounding();
    send_item(KIND_CLEAR, 7'd0, 9'd0, 12'd0);
    repeat (4) send_item(KIND_ACC, REF_CH2, 9'd5, 12'd4095);
    send_item(KIND_CORRECT, 7'd30, 9'd5, 12'd0);
    send_item(KIND_ACC, REF_CH0, 9'd7, 12'd1);
    send_item(KIND_ACC, REF_CH1, 9'd7, 12'd2);
    send_item(KIND_CORRECT, 7'd30, 9'd7, 12'd100);
    send_item(KIND_CORRECT, 7'd30, 9'd5, 12'd4095);
    wait_results();
  endtask

  // Stall the receiver for a long stretch while the sender streams corrections.
  task automatic test_back_pressure();
    send_item(KIND_CLEAR, 7'd5, 9'd9, 12'd9);
    send_item(KIND_ACC, REF_CH0, 9'd100, 12'd2000);
    tx_idle = 1'b0;
    hold_left = 64;
    for (int n = 0; n < 24; n++)
      send_item(KIND_CORRECT, rand_channel(),
                ($urandom_range(0, 1) == 0) ? 9'd100 : rand_index(), rand_sample());
    tx_idle = 1'b1;
    wait_results();
  endtask

  task automatic test_random_frames();
    logic [3:0]       mask;
    logic [IDX_W-1:0] pool [4];
    int               npool;
    int               ncorr;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] idx;
    while (items_sent < ITEM_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_item(KIND_CLEAR, rand_channel(), rand_index(), rand_sample());
      mask = 4'($urandom_range(0, 15));
      npool = $urandom_range(1, 4);
      for (int i = 0; i < npool; i++) pool[i] = rand_index();
      for (int r = 0; r < 4; r++) begin
        if (mask[r]) begin
          for (int i = 0; i < npool; i++) begin
            send_item(KIND_ACC, ref_channel(r), pool[i], rand_sample());
            if ($urandom_range(0, 7) == 0)
              send_item(KIND_ACC, ref_channel(r), pool[i], rand_sample());
          end
        end
      end
      ncorr = $urandom_range(4, 12);
      for (int n = 0; n < ncorr; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: send_item(KIND_UNUSED, rand_channel(), rand_index(), rand_sample());
            1: send_item(KIND_ACC, rand_channel(), rand_index(), rand_sample());
            default: send_item(KIND_ACC, ref_channel($urandom_range(0, 3)),
                               pool[0], rand_sample());
          endcase
        end
        ch = ($urandom_range(0, 4) == 0) ? ref_channel($urandom_range(0, 3)) : rand_channel();
        idx = ($urandom_range(0, 4) == 0) ? rand_index() : pool[$urandom_range(0, npool - 1)];
        send_item(KIND_CORRECT, ch, idx, rand_sample());
      end
      if ($urandom_range(0, 5) == 0) wait_results();
    end
  endtask

  initial begin
    foreach (ref_sums[i]) ref_sums[i] = '0;
    ref_mask = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_no_reference();
    test_ignored_items();
    test_full_sum_and_wrap();
    test_saturation_and_rounding();
    test_back_pressure();
    test_random_frames();
    wait_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fpn_average_subtract_tb passed");
    end else begin
      $display("fpn_average_subtract_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fpnas_pkg.sv
src/fpnas_sum_mem.sv
src/fpnas_avg.sv
src/fpnas_out_buf.sv
src/fpn_average_subtract.sv
verif/fpn_average_subtract_tb.sv
